// File: sv/bpts_pkg.sv
// ----------------------------------------------------------------------------
// bpts_pkg: shared definitions for the button packet pan/tilt stepper
// Character codes, LED color codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package bpts_pkg;

	localparam int BYTE_W   = 8;
	localparam int POS_W    = 5;
	localparam int COLOUR_W = 2;
	localparam int OUT_W    = 16;

	// Default span of each axis, in steps.
	localparam int POS_STEPS_DEF = 20;

	localparam logic [BYTE_W-1:0] SETTLE_RESET = 8'd10;

	localparam logic [BYTE_W-1:0] CH_START = 8'h21; // '!'
	localparam logic [BYTE_W-1:0] CH_TYPE  = 8'h42; // 'B'
	localparam logic [BYTE_W-1:0] CH_UP    = 8'h35; // '5'
	localparam logic [BYTE_W-1:0] CH_DOWN  = 8'h36; // '6'
	localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h37; // '7'
	localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h38; // '8'
	localparam logic [BYTE_W-1:0] CH_PRESS = 8'h31; // '1'

	localparam logic [COLOUR_W-1:0] COL_GREEN  = 2'd0;
	localparam logic [COLOUR_W-1:0] COL_RED    = 2'd1;
	localparam logic [COLOUR_W-1:0] COL_YELLOW = 2'd2;

	typedef struct packed {
		logic                check_failed;
		logic                packet_accepted;
		logic                ready_res;
		logic [COLOUR_W-1:0] led_colour;
		logic [POS_W-1:0]    tilt_pos;
		logic [POS_W-1:0]    pan_pos;
	} result_t;

endpackage

// File: sv/bpts_core.sv
// ----------------------------------------------------------------------------
// bpts_core: packet parser and axis stepper state
// Holds the parse and motion state and works out the next state and the
// result for one byte or tick combinationally.
// ----------------------------------------------------------------------------
module bpts_core #(
	parameter int POS_STEPS = bpts_pkg::POS_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        cmd,
	input  logic [bpts_pkg::BYTE_W-1:0] rx_byte,
	input  logic [bpts_pkg::BYTE_W-1:0] settle_ticks,
	output bpts_pkg::result_t           result
);

	localparam int STEP_W = $clog2(POS_STEPS + 1);
	localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(POS_STEPS);

	typedef enum logic [2:0] {
		PH_START,
		PH_TYPE,
		PH_BUTTON,
		PH_HIT,
		PH_CHECK
	} phase_t;

	phase_t                              phase_q, phase_d;
	logic [bpts_pkg::BYTE_W-1:0]         button_q, button_d;
	logic [bpts_pkg::BYTE_W-1:0]         hit_q, hit_d;
	logic [STEP_W-1:0]                   pan_q, pan_d;
	logic [STEP_W-1:0]                   tilt_q, tilt_d;
	logic [3:0]                          held_q, held_d;
	logic                                ready_q, ready_d;
	logic [bpts_pkg::BYTE_W-1:0]         settle_q, settle_d;
	logic [bpts_pkg::COLOUR_W-1:0]       colour_q, colour_d;
	logic                                acc, bad;
	logic [bpts_pkg::BYTE_W-1:0]         sum;
	logic [3:0]                          dir;
	logic [STEP_W-1:0]                   tilt_mid, pan_mid;
	logic [STEP_W+bpts_pkg::POS_W-1:0]   pan_ext, tilt_ext;

	always_comb begin
		case (button_q)
			bpts_pkg::CH_UP:    dir = 4'b0001;
			bpts_pkg::CH_DOWN:  dir = 4'b0010;
			bpts_pkg::CH_LEFT:  dir = 4'b0100;
			bpts_pkg::CH_RIGHT: dir = 4'b1000;
			default:            dir = 4'b0000;
		endcase
	end

	assign sum = bpts_pkg::CH_START + bpts_pkg::CH_TYPE + button_q + hit_q;

	always_comb begin
		phase_d  = phase_q;
		button_d = button_q;
		hit_d    = hit_q;
		pan_d    = pan_q;
		tilt_d   = tilt_q;
		held_d   = held_q;
		ready_d  = ready_q;
		settle_d = settle_q;
		colour_d = colour_q;
		acc      = 1'b0;
		bad      = 1'b0;
		tilt_mid = tilt_q;
		pan_mid  = pan_q;
		if (cmd) begin
			// Opposite directions are applied in turn: up, down, left, right.
			if (!ready_q) begin
				if (held_q[0] && tilt_q != '0) tilt_mid = tilt_q - 1'b1;
				if (held_q[1] && tilt_mid < STEP_MAX) tilt_d = tilt_mid + 1'b1;
				else tilt_d = tilt_mid;
				if (held_q[2] && pan_q != '0) pan_mid = pan_q - 1'b1;
				if (held_q[3] && pan_mid < STEP_MAX) pan_d = pan_mid + 1'b1;
				else pan_d = pan_mid;
			end
			if (settle_q != '0) begin
				settle_d = settle_q - 1'b1;
				if (settle_q == 8'd1) begin
					ready_d  = 1'b1;
					colour_d = bpts_pkg::COL_GREEN;
				end
			end
		end else begin
			case (phase_q)
				PH_TYPE: begin
					phase_d = (rx_byte == bpts_pkg::CH_TYPE) ? PH_BUTTON : PH_START;
				end
				PH_BUTTON: begin
					button_d = rx_byte;
					phase_d  = PH_HIT;
				end
				PH_HIT: begin
					hit_d   = rx_byte;
					phase_d = PH_CHECK;
				end
				PH_CHECK: begin
					phase_d = PH_START;
					if (rx_byte == ~sum) begin
						acc = 1'b1;
						if (dir != 4'b0000) begin
							if (hit_q == bpts_pkg::CH_PRESS) begin
								held_d   = held_q | dir;
								ready_d  = 1'b0;
								settle_d = '0;
								colour_d = bpts_pkg::COL_RED;
							end else begin
								held_d   = held_q & ~dir;
								settle_d = settle_ticks;
								if (settle_ticks == '0) begin
									ready_d  = 1'b1;
									colour_d = bpts_pkg::COL_GREEN;
								end else begin
									colour_d = bpts_pkg::COL_YELLOW;
								end
							end
						end
					end else begin
						bad = 1'b1;
					end
				end
				default: begin
					phase_d = (rx_byte == bpts_pkg::CH_START) ? PH_TYPE : PH_START;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			button_q <= '0;
			hit_q    <= '0;
			pan_q    <= '0;
			tilt_q   <= '0;
			held_q   <= '0;
			ready_q  <= 1'b1;
			settle_q <= '0;
			colour_q <= bpts_pkg::COL_GREEN;
		end else if (en) begin
			phase_q  <= phase_d;
			button_q <= button_d;
			hit_q    <= hit_d;
			pan_q    <= pan_d;
			tilt_q   <= tilt_d;
			held_q   <= held_d;
			ready_q  <= ready_d;
			settle_q <= settle_d;
			colour_q <= colour_d;
		end
	end

	// Positions are reported as the low five bits of the step counts.
	assign pan_ext  = {{bpts_pkg::POS_W{1'b0}}, pan_d};
	assign tilt_ext = {{bpts_pkg::POS_W{1'b0}}, tilt_d};

	always_comb begin
		result.pan_pos         = pan_ext[bpts_pkg::POS_W-1:0];
		result.tilt_pos        = tilt_ext[bpts_pkg::POS_W-1:0];
		result.led_colour      = colour_d;
		result.ready_res       = ready_d;
		result.packet_accepted = acc;
		result.check_failed    = bad;
	end

endmodule

// File: sv/button_packet_pan_tilt_stepper.sv
// ----------------------------------------------------------------------------
// button_packet_pan_tilt_stepper: button packet parser driving a pan/tilt pair
// Parses five-byte button packets and steps the two axes on movement ticks.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: cmd; tdata[7:0]: rx_byte
//  m_axis    out        tdata: pan_pos, tilt_pos, led_colour, ready_res,
//                       packet_accepted, check_failed (one per input)
//  cfg       in         settle_ticks, written when cfg_we is high
//
// One transaction in gives one transaction out. A transaction is captured in
// an input register, processed against the parser and axis state as it
// leaves, and the result lands in the output register: one transaction per
// cycle sustained while m_axis is ready. When m_axis stalls, one transaction
// waits in the input register and s_axis_tready drops. Reset is asynchronous
// and leaves the parser waiting for a start byte, both axes at zero, ready.
//
module button_packet_pan_tilt_stepper #(
	parameter int POS_STEPS = bpts_pkg::POS_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [bpts_pkg::BYTE_W-1:0] s_axis_tdata,  // [7:0] rx_byte
	input  logic                        s_axis_tuser,  // cmd
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// [4:0] pan_pos, [9:5] tilt_pos, [11:10] led_colour, [12] ready_res,
	// [13] packet_accepted, [14] check_failed, [15] zero
	output logic [bpts_pkg::OUT_W-1:0]  m_axis_tdata,
	input  logic                        cfg_we,
	input  logic [bpts_pkg::BYTE_W-1:0] cfg_wdata
);

	logic                        valid_s1;
	logic                        cmd_s1;
	logic [bpts_pkg::BYTE_W-1:0] byte_s1;
	logic                        out_valid_q;
	logic [bpts_pkg::OUT_W-1:0]  out_data_q;
	logic [bpts_pkg::BYTE_W-1:0] settle_ticks_q;
	logic                        advance;
	bpts_pkg::result_t           result;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_ticks_q <= bpts_pkg::SETTLE_RESET;
		end else if (cfg_we) begin
			settle_ticks_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	bpts_core #(
		.POS_STEPS(POS_STEPS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.cmd         (cmd_s1),
		.rx_byte     (byte_s1),
		.settle_ticks(settle_ticks_q),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {1'b0, result.check_failed, result.packet_accepted,
				result.ready_res, result.led_colour, result.tilt_pos, result.pan_pos};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
